// ===== design/ovn_pkg.sv =====
package ovn_pkg;

	localparam int GRID_W_LOG2 = 6;
	localparam int GRID_H_LOG2 = 6;
	localparam int ADDR_W      = GRID_W_LOG2 + GRID_H_LOG2;
	localparam int GRID_CELLS  = 1 << ADDR_W;
	localparam int SEED_W      = 16;
	localparam int SH_W        = $clog2(GRID_W_LOG2 + 1);

	localparam logic [31:0] WEIGHT_ONE = 32'h0001_0000;

	// Shared divider geometry.
	localparam int DVD_W  = 64;
	localparam int DVS_W  = 43;
	localparam int STEP_W = 7;

	localparam logic CFG_OCTAVE_COUNT = 1'b0;
	localparam logic CFG_OCTAVE_BIAS  = 1'b1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

endpackage

// ===== design/ovn_if.sv =====
interface ovn_in_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [5:0]                 cell_x;
	logic [5:0]                 cell_y;
	logic [ovn_pkg::SEED_W-1:0] seed_value;

	modport source (output valid, cmd, cell_x, cell_y, seed_value, input ready);
	modport sink (input valid, cmd, cell_x, cell_y, seed_value, output ready);
endinterface

interface ovn_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] noise_value;

	modport source (output valid, noise_value, input ready);
	modport sink (input valid, noise_value, output ready);
endinterface

// ===== design/octave_value_noise_2d.sv =====
// A load beat writes one seed. A query walks the octaves one at a time:
// four seed reads, a nine-step interpolation on the shared 32x32
// multiplier, then a 40-step weight division on the shared serial divider,
// which ends with its done strobe. A 64-step final normalising division and
// the output stage follow. An octave count of zero counts as one. Most of a
// query's time is spent in the divider. The block is not ready while a query
// runs. A finished result waits in the output register while the next beat
// is taken. Seeds are undefined until loaded.
module octave_value_noise_2d (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	ovn_in_if.sink      query,
	ovn_out_if.source   result
);

	localparam int XW = ovn_pkg::GRID_W_LOG2;
	localparam int YW = ovn_pkg::GRID_H_LOG2;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD   = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIVW = 6'b001000,
		ST_DIVF = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t                        state_q;
	logic [2:0]                    count_q;
	logic [15:0]                   bias_q;
	logic [XW-1:0]                 x_q;
	logic [YW-1:0]                 y_q;
	logic [2:0]                    oct_q;
	logic [3:0]                    step_q;
	logic [ovn_pkg::SEED_W-1:0]    seed_q [4];
	logic [63:0]                   prod_q;
	logic [48:0]                   acc_q;
	logic [31:0]                   top_q;
	logic [31:0]                   bot_q;
	logic [23:0]                   v_q;
	logic [31:0]                   weight_q;
	logic [34:0]                   total_q;
	logic [63:0]                   sum_q;
	logic [15:0]                   res_q;
	logic                          out_valid_q;
	logic [15:0]                   out_data_q;

	logic [2:0]                    n_last;
	logic [15:0]                   bias_eff;
	logic [ovn_pkg::SH_W-1:0]      sh;
	logic [16:0]                   pitch_full;
	logic [16:0]                   mask_full;
	logic [XW-1:0]                 x_off, x1, x2;
	logic [YW-1:0]                 y_off, y1, y2;
	logic [15:0]                   bx, by;
	logic [16:0]                   omb, omby;
	logic [XW+15:0]                bx_wide;
	logic [YW+15:0]                by_wide;
	logic [31:0]                   mul_a, mul_b;
	logic [49:0]                   v_sum;
	logic [64:0]                   sum_next;
	logic [64:0]                   fin_dvd;
	logic [39:0]                   w_dvd;
	logic [ovn_pkg::ADDR_W-1:0]    raddr;
	logic [ovn_pkg::SEED_W-1:0]    rdata;
	logic                          accept;
	logic                          load_we;
	ovn_pkg::div_req_t             div_req;
	logic                          div_busy;
	logic                          div_done;
	logic [ovn_pkg::DVD_W-1:0]     div_q;

	assign accept  = query.valid && query.ready;
	assign load_we = accept && (query.cmd == ovn_pkg::CMD_LOAD);
	assign query.ready = (state_q == ST_IDLE);

	assign n_last   = (count_q == 3'd0) ? 3'd0 : count_q - 3'd1;
	assign bias_eff = (bias_q == 16'd0) ? 16'd1 : bias_q;

	// Lattice of the current octave; the pitch never drops below one.
	assign sh         = (oct_q < 3'(XW)) ? ovn_pkg::SH_W'(XW) - ovn_pkg::SH_W'(oct_q) : '0;
	assign pitch_full = 17'd1 << sh;
	assign mask_full  = pitch_full - 17'd1;
	assign x_off      = x_q & mask_full[XW-1:0];
	assign y_off      = y_q & mask_full[YW-1:0];
	assign x1         = x_q & ~mask_full[XW-1:0];
	assign y1         = y_q & ~mask_full[YW-1:0];
	assign x2         = x1 + pitch_full[XW-1:0];
	assign y2         = y1 + pitch_full[YW-1:0];
	assign bx_wide    = {x_off, 16'd0} >> sh;
	assign by_wide    = {y_off, 16'd0} >> sh;
	assign bx         = bx_wide[15:0];
	assign by         = by_wide[15:0];
	assign omb        = 17'h10000 - {1'b0, bx};
	assign omby       = 17'h10000 - {1'b0, by};

	always_comb begin
		case (step_q[1:0])
			2'd0:    raddr = {y1, x1};
			2'd1:    raddr = {y1, x2};
			2'd2:    raddr = {y2, x1};
			default: raddr = {y2, x2};
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_MUL) begin
			case (step_q)
				4'd0:    begin mul_a = 32'(omb);  mul_b = 32'(seed_q[0]); end
				4'd1:    begin mul_a = 32'(bx);   mul_b = 32'(seed_q[1]); end
				4'd2:    begin mul_a = 32'(omb);  mul_b = 32'(seed_q[2]); end
				4'd3:    begin mul_a = 32'(bx);   mul_b = 32'(seed_q[3]); end
				4'd4:    begin mul_a = 32'(omby); mul_b = top_q; end
				4'd5:    begin mul_a = 32'(by);   mul_b = bot_q; end
				4'd7:    begin mul_a = 32'(v_q);  mul_b = weight_q; end
				default: begin mul_a = '0;        mul_b = '0; end
			endcase
		end
	end

	assign v_sum    = 50'(acc_q) + 50'(prod_q[48:0]) + 50'h80_0000;
	assign sum_next = {1'b0, sum_q} + {1'b0, prod_q};
	assign fin_dvd  = {1'b0, sum_q} + 65'({total_q, 7'd0});
	assign w_dvd    = {weight_q, 8'd0} + 40'(bias_eff[15:1]);

	always_comb begin
		div_req = '0;
		if (state_q == ST_MUL && step_q == 4'd8) begin
			div_req.start    = 1'b1;
			div_req.dividend = {w_dvd, 24'd0};
			div_req.divisor  = ovn_pkg::DVS_W'(bias_eff);
			div_req.steps    = ovn_pkg::STEP_W'(40);
		end else if (state_q == ST_DIVW && div_done && oct_q == n_last) begin
			div_req.start    = 1'b1;
			div_req.dividend = fin_dvd[64] ? '1 : fin_dvd[63:0];
			div_req.divisor  = {total_q, 8'd0};
			div_req.steps    = ovn_pkg::STEP_W'(64);
		end
	end

	ovn_ram #(
		.WIDTH(ovn_pkg::SEED_W),
		.DEPTH(ovn_pkg::GRID_CELLS)
	) u_seeds (
		.clk   (clk),
		.we    (load_we),
		.waddr ({query.cell_y[YW-1:0], query.cell_x[XW-1:0]}),
		.wdata (query.seed_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	ovn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd5;
			bias_q  <= 16'd512;
		end else if (cfg_we) begin
			case (cfg_index)
				ovn_pkg::CFG_OCTAVE_COUNT: count_q <= cfg_data[2:0];
				ovn_pkg::CFG_OCTAVE_BIAS:  bias_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			oct_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && query.cmd == ovn_pkg::CMD_QUERY) begin
						state_q <= ST_RD;
						step_q  <= '0;
						oct_q   <= '0;
					end
				end
				ST_RD: begin
					if (step_q == 4'd4) begin
						state_q <= ST_MUL;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_MUL: begin
					if (step_q == 4'd8) begin
						state_q <= ST_DIVW;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						if (oct_q == n_last) begin
							state_q <= ST_DIVF;
						end else begin
							oct_q   <= oct_q + 3'd1;
							state_q <= ST_RD;
							step_q  <= '0;
						end
					end
				end
				ST_DIVF: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// The previous result must have left before this one lands.
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			x_q      <= query.cell_x[XW-1:0];
			y_q      <= query.cell_y[YW-1:0];
			weight_q <= ovn_pkg::WEIGHT_ONE;
			total_q  <= '0;
			sum_q    <= '0;
		end
		if (state_q == ST_RD && step_q != 4'd0) begin
			seed_q[step_q[1:0] - 2'd1] <= rdata;
		end
		if (state_q == ST_MUL) begin
			case (step_q)
				4'd1, 4'd3, 4'd5: acc_q <= prod_q[48:0];
				4'd2:    top_q <= 32'(acc_q + prod_q[48:0]);
				4'd4:    bot_q <= 32'(acc_q + prod_q[48:0]);
				4'd6:    v_q   <= v_sum[47:24];
				4'd8: begin
					sum_q   <= sum_next[64] ? '1 : sum_next[63:0];
					total_q <= total_q + 35'(weight_q);
				end
				default: ;
			endcase
		end
		if (state_q == ST_DIVW && div_done) begin
			weight_q <= (div_q[39:32] != 8'd0) ? 32'hFFFF_FFFF : div_q[31:0];
		end
		if (state_q == ST_DIVF && div_done) begin
			res_q <= (div_q[63:16] != 48'd0) ? 16'hFFFF : div_q[15:0];
		end
		if (state_q == ST_FIN && !out_valid_q) begin
			out_data_q <= res_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.noise_value = out_data_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_busy)
		else $error("divider started while busy");

	a_oct_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (oct_q <= n_last))
		else $error("octave index beyond octave count");

	a_mul_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (step_q <= 4'd8))
		else $error("interpolation step out of range");

	a_fin_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVF && div_done) |=> (state_q == ST_FIN))
		else $error("final division result not taken");

endmodule

// ===== design/ovn_ram.sv =====
module ovn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/ovn_div.sv =====
module ovn_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ovn_pkg::div_req_t          req,
	output logic                       busy,
	output logic                       done,
	output logic [ovn_pkg::DVD_W-1:0]  quotient
);

	logic                        busy_q;
	logic                        done_q;
	logic [ovn_pkg::STEP_W-1:0]  cnt_q;
	logic [ovn_pkg::DVS_W-1:0]   rem_q;
	logic [ovn_pkg::DVS_W-1:0]   dvs_q;
	logic [ovn_pkg::DVD_W-1:0]   dvd_q;
	logic [ovn_pkg::DVD_W-1:0]   quo_q;
	logic [ovn_pkg::DVS_W:0]     trial;
	logic                        fits;

	// One quotient bit per cycle, restoring.
	assign trial = {rem_q, dvd_q[ovn_pkg::DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ovn_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			dvd_q <= req.dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? ovn_pkg::DVS_W'(trial - {1'b0, dvs_q})
			              : trial[ovn_pkg::DVS_W-1:0];
			dvd_q <= {dvd_q[ovn_pkg::DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[ovn_pkg::DVD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int GRID_W       = 1 << ovn_pkg::GRID_W_LOG2;
	localparam int GRID_H       = 1 << ovn_pkg::GRID_H_LOG2;
	localparam int AXIS_POINTS  = 20;
	localparam int SETTLE_TICKS = 600;
	localparam int CYCLE_LIMIT  = 3000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	ovn_in_if  query ();
	ovn_out_if result ();

	octave_value_noise_2d dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.query     (query),
		.result    (result)
	);

	// Shadow copy of the block's state and settings.
	logic [ovn_pkg::SEED_W-1:0] seed_copy [ovn_pkg::GRID_CELLS];
	logic [2:0]                 octaves_set;
	logic [15:0]                bias_set;

	logic [15:0] noise_due [$];
	int          mismatches;
	bit          failed;
	bit          idle_on;
	int          hold_left;
	longint      cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= ovn_pkg::CFG_OCTAVE_COUNT;
		cfg_data     <= '0;
		query.valid  <= 1'b0;
		query.cmd    <= ovn_pkg::CMD_LOAD;
		query.cell_x <= '0;
		query.cell_y <= '0;
		query.seed_value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// The long hold-off is counted down here; the receiver only looks at it.
	initial begin
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0)
				hold_left--;
		end
	end

	// Queried cells stay within eight of the grid corners, so every octave
	// only touches the lattice points listed by axis_point.
	function automatic logic [5:0] pick_coord();
		logic [3:0] r;
		r = 4'($urandom);
		return r[3] ? {3'b111, r[2:0]} : {3'b000, r[2:0]};
	endfunction

	function automatic logic [5:0] axis_point(int k);
		if (k < 9)
			return 6'(k);
		else if (k == 9)
			return 6'd16;
		else if (k == 10)
			return 6'd32;
		else if (k == 11)
			return 6'd48;
		else
			return 6'(56 + k - 12);
	endfunction

	function automatic logic [63:0] octave_sample(int x, int y, int o);
		int sh, pitch, x1, y1, x2, y2;
		logic [63:0] bx, by, top, bot, v48;
		sh = (o < ovn_pkg::GRID_W_LOG2) ? ovn_pkg::GRID_W_LOG2 - o : 0;
		pitch = 1 << sh;
		x1 = x & ~(pitch - 1);
		y1 = y & ~(pitch - 1);
		x2 = (x1 + pitch) & (GRID_W - 1);
		y2 = (y1 + pitch) & (GRID_H - 1);
		bx = (64'(x - x1) << 16) >> sh;
		by = (64'(y - y1) << 16) >> sh;
		top = (64'(ovn_pkg::WEIGHT_ONE) - bx) * seed_copy[(y1 << ovn_pkg::GRID_W_LOG2) | x1]
			+ bx * seed_copy[(y1 << ovn_pkg::GRID_W_LOG2) | x2];
		bot = (64'(ovn_pkg::WEIGHT_ONE) - bx) * seed_copy[(y2 << ovn_pkg::GRID_W_LOG2) | x1]
			+ bx * seed_copy[(y2 << ovn_pkg::GRID_W_LOG2) | x2];
		v48 = (64'(ovn_pkg::WEIGHT_ONE) - by) * top + by * bot;
		return (v48 + (64'd1 << 23)) >> 24;
	endfunction

	function automatic logic [15:0] predict_noise(int x, int y);
		int n;
		logic [63:0] bias, weight, total, sum, term, den, res;
		n = (octaves_set == 0) ? 1 : octaves_set;
		bias = (bias_set == 0) ? 64'd1 : 64'(bias_set);
		weight = 64'(ovn_pkg::WEIGHT_ONE);
		total = 0;
		sum = 0;
		for (int o = 0; o < n; o++) begin
			term = octave_sample(x, y, o) * weight;
			total += weight;
			sum = (sum > ~64'd0 - term) ? ~64'd0 : sum + term;
			weight = ((weight << 8) + (bias >> 1)) / bias;
			if (weight > 64'hFFFF_FFFF)
				weight = 64'hFFFF_FFFF;
		end
		den = total << 8;
		if (sum > ~64'd0 - (den >> 1))
			res = ~64'd0 / den;
		else
			res = (sum + (den >> 1)) / den;
		if (res > 64'd65535)
			res = 64'd65535;
		return res[15:0];
	endfunction

	// Receiver: checks each result beat, stalls in random bursts if idle_on.
	initial begin
		int stall_left;
		logic [15:0] want;
		stall_left = 0;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				if (noise_due.size() == 0) begin
					failed = 1'b1;
					if (mismatches < 10)
						$display("unexpected result beat: noise %h", result.noise_value);
					mismatches++;
				end else begin
					want = noise_due.pop_front();
					if (result.noise_value !== want) begin
						failed = 1'b1;
						if (mismatches < 10)
							$display("noise mismatch: expected %h, got %h", want,
								result.noise_value);
						mismatches++;
					end
				end
			end
			if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 6);
			if (hold_left > 0) begin
				result.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	task automatic send_beat(logic cmd, logic [5:0] x, logic [5:0] y, logic [15:0] seed);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			query.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		query.valid      <= 1'b1;
		query.cmd        <= cmd;
		query.cell_x     <= x;
		query.cell_y     <= y;
		query.seed_value <= seed;
		do @(posedge clk); while (!query.ready);
		if (cmd == ovn_pkg::CMD_LOAD)
			seed_copy[(int'(y) << ovn_pkg::GRID_W_LOG2) | int'(x)] = seed;
		else
			noise_due.push_back(predict_noise(x, y));
	endtask

	task automatic drain();
		query.valid <= 1'b0;
		while (noise_due.size() != 0)
			@(posedge clk);
		// A load may still be in flight behind the last query.
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic set_octaves(logic [2:0] count, logic [15:0] bias);
		logic [15:0] raw;
		drain();
		raw = {13'($urandom_range(0, 8191)), count};
		cfg_we    <= 1'b1;
		cfg_index <= ovn_pkg::CFG_OCTAVE_COUNT;
		cfg_data  <= raw;
		@(posedge clk);
		cfg_index <= ovn_pkg::CFG_OCTAVE_BIAS;
		cfg_data  <= bias;
		@(posedge clk);
		cfg_we <= 1'b0;
		octaves_set = raw[2:0];
		bias_set    = bias;
	endtask

	// Every lattice point that a query can reach is loaded first, so no query
	// ever reads an unwritten entry.
	task automatic test_fill_grid();
		for (int i = 0; i < AXIS_POINTS; i++)
			for (int j = 0; j < AXIS_POINTS; j++)
				send_beat(ovn_pkg::CMD_LOAD, axis_point(i), axis_point(j), 16'($urandom));
	endtask

	task automatic test_corners();
		send_beat(ovn_pkg::CMD_LOAD, 6'd63, 6'd63, 16'hFFFF);
		send_beat(ovn_pkg::CMD_LOAD, 6'd0, 6'd0, 16'h0000);
		send_beat(ovn_pkg::CMD_LOAD, 6'd63, 6'd0, 16'hFFFF);
		send_beat(ovn_pkg::CMD_LOAD, 6'd0, 6'd63, 16'hFFFF);
		// Reset settings first, then the extremes of both registers.
		send_beat(ovn_pkg::CMD_QUERY, 6'd0, 6'd0, 16'h0);
		send_beat(ovn_pkg::CMD_QUERY, 6'd63, 6'd63, 16'hFFFF);
		set_octaves(3'd0, 16'd0);
		send_beat(ovn_pkg::CMD_QUERY, 6'd63, 6'd0, 16'h0);
		send_beat(ovn_pkg::CMD_QUERY, 6'd0, 6'd63, 16'h0);
		set_octaves(3'd7, 16'd128);
		send_beat(ovn_pkg::CMD_QUERY, 6'd63, 6'd63, 16'h0);
		send_beat(ovn_pkg::CMD_QUERY, 6'd7, 6'd56, 16'h0);
		set_octaves(3'd7, 16'd0);
		send_beat(ovn_pkg::CMD_QUERY, 6'd62, 6'd63, 16'h0);
		send_beat(ovn_pkg::CMD_QUERY, 6'd1, 6'd1, 16'h0);
		set_octaves(3'd1, 16'd65535);
		send_beat(ovn_pkg::CMD_QUERY, 6'd63, 6'd63, 16'h0);
		set_octaves(3'd7, 16'd65535);
		send_beat(ovn_pkg::CMD_QUERY, 6'd5, 6'd58, 16'h0);
		send_beat(ovn_pkg::CMD_LOAD, 6'd5, 6'd58, 16'h0001);
		send_beat(ovn_pkg::CMD_QUERY, 6'd5, 6'd58, 16'h0);
	endtask

	task automatic random_beats(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 6)
				send_beat(ovn_pkg::CMD_QUERY, pick_coord(), pick_coord(), 16'($urandom));
			else
				send_beat(ovn_pkg::CMD_LOAD, pick_coord(), pick_coord(), 16'($urandom));
		end
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 5; p++) begin
			set_octaves(3'($urandom), (p == 0) ? 16'd256 : 16'($urandom_range(0, 65535)));
			random_beats(160);
		end
	endtask

	task automatic test_back_pressure();
		set_octaves(3'd2, 16'd300);
		hold_left = 400;
		random_beats(30);
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		set_octaves(3'd4, 16'd512);
		random_beats(120);
	endtask

	initial begin
		mismatches = 0;
		failed     = 1'b0;
		idle_on    = 1'b1;
		octaves_set = 3'd5;
		bias_set    = 16'd512;
		@(posedge arst_n);
		@(posedge clk);
		test_fill_grid();
		test_corners();
		test_random_settings();
		test_back_pressure();
		test_no_idle();
		drain();
		if (!failed && noise_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== octave_value_noise_2d.f =====
design/ovn_pkg.sv
design/ovn_if.sv
design/ovn_ram.sv
design/ovn_div.sv
design/octave_value_noise_2d.sv
tb/tb.sv
